### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks on a clock with synchronous reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent must hold when antecedent is seen
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold after antecedent
`define ASSERT_AFTER_TWO(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error("assertion failed");

`endif

### rtl/ild_pkg.sv
// ---------------------------------------------------------------------------
// ild_pkg
// shared types and constants of the instruction length decoder
// ---------------------------------------------------------------------------
package ild_pkg;

   localparam int WINDOW_BYTES     = 24;
   localparam int MAX_PREFIX_BYTES = 15;
   localparam int IDX_W            = $clog2(WINDOW_BYTES);
   localparam int PFX_W            = $clog2(MAX_PREFIX_BYTES + 1);
   localparam int LEN_W            = 5;
   localparam int ADD_W            = 4;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

   // how the back end forms the length
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FIXED,
      KIND_MODRM
   } kind_type;

   // classified word handed from front to back
   typedef struct packed {
      kind_type         kind;
      logic [PFX_W-1:0] pfx_cnt;
      logic [ADD_W-1:0] add;
      logic [7:0]       modrm;
      logic [7:0]       sib;
   } item_type;

endpackage

### rtl/ild_front.sv
// ---------------------------------------------------------------------------
// ild_front
// skips prefixes, picks the opcode and classifies the instruction form
// ---------------------------------------------------------------------------
module ild_front import ild_pkg::*; (
   input  logic [63:0] code_lo,
   input  logic [63:0] code_mid,
   input  logic [63:0] code_hi,
   output item_type    item
);

   logic [8*WINDOW_BYTES-1:0] w;
   logic [7:0]                byts [WINDOW_BYTES];
   logic                      found;
   logic                      rexw;
   logic [PFX_W-1:0]          cnt;
   logic [IDX_W-1:0]          idx;
   logic [7:0]                op;
   logic [7:0]                b1;
   logic [7:0]                b2;
   logic [7:0]                b3;

   // split the window into bytes
   always_comb begin
      w = {code_hi, code_mid, code_lo};
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         byts[k] = w[8*k +: 8];
      end
   end

   // prefix scan, remembering rex.w of the last rex byte
   always_comb begin
      found = 1'b0;
      rexw  = 1'b0;
      cnt   = '0;
      for (int k = 0; k < MAX_PREFIX_BYTES; k++) begin
         if (!found) begin
            if (byts[k][7:4] == 4'h4) begin
               rexw = byts[k][3];
               cnt  = PFX_W'(k + 1);
            end else if (byts[k] == 8'h66 || byts[k] == 8'h67 || byts[k] == 8'hF0 ||
                         byts[k] == 8'hF2 || byts[k] == 8'hF3) begin
               cnt = PFX_W'(k + 1);
            end else begin
               found = 1'b1;
            end
         end
      end
   end

   // opcode and the bytes after it
   always_comb begin
      idx = IDX_W'(cnt);
      op  = byts[idx];
      b1  = byts[idx + IDX_W'(1)];
      b2  = byts[idx + IDX_W'(2)];
      b3  = byts[idx + IDX_W'(3)];
   end

   // opcode classification
   always_comb begin
      item.pfx_cnt = cnt;
      item.kind    = KIND_NONE;
      item.add     = '0;
      item.modrm   = b1;
      item.sib     = b2;
      if (found) begin
         unique case (op) inside
            8'h0F: begin
               item.modrm = b2;
               item.sib   = b3;
               unique case (b1) inside
                  [8'h80:8'h8F]: begin
                     item.kind = KIND_FIXED;
                     item.add  = ADD_W'(6);
                  end
                  8'h1E, 8'h1F: begin
                     item.kind = KIND_MODRM;
                     item.add  = ADD_W'(2);
                  end
                  8'h05, 8'h34: begin
                     item.kind = KIND_FIXED;
                     item.add  = ADD_W'(2);
                  end
                  default: item.kind = KIND_NONE;
               endcase
            end
            [8'h50:8'h5F], 8'hC3, 8'hCC, 8'h90: begin
               item.kind = KIND_FIXED;
               item.add  = ADD_W'(1);
            end
            [8'h70:8'h7F], 8'hEB, 8'h6A: begin
               item.kind = KIND_FIXED;
               item.add  = ADD_W'(2);
            end
            8'hE9, 8'hE8, 8'h68: begin
               item.kind = KIND_FIXED;
               item.add  = ADD_W'(5);
            end
            [8'hB8:8'hBF]: begin
               item.kind = KIND_FIXED;
               item.add  = rexw ? ADD_W'(9) : ADD_W'(5);
            end
            8'hC2: begin
               item.kind = KIND_FIXED;
               item.add  = ADD_W'(3);
            end
            8'h80, 8'h83: begin
               item.kind = KIND_MODRM;
               item.add  = ADD_W'(2);
            end
            8'h81, 8'hC7: begin
               item.kind = KIND_MODRM;
               item.add  = ADD_W'(5);
            end
            8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23, 8'h29, 8'h2B, 8'h31, 8'h33,
            8'h39, 8'h3B, 8'h63, 8'h85, 8'h86, 8'h87, 8'h89, 8'h8B, 8'h8D, 8'h8F,
            8'hFF: begin
               item.kind = KIND_MODRM;
               item.add  = ADD_W'(1);
            end
            default: item.kind = KIND_NONE;
         endcase
      end
   end

endmodule

### rtl/ild_queue.sv
// ---------------------------------------------------------------------------
// ild_queue
// short fifo of classified words between front and back
// ---------------------------------------------------------------------------
module ild_queue import ild_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     empty,
   output logic     full
);

   item_type          mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_item = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/ild_back.sv
// ---------------------------------------------------------------------------
// ild_back
// sizes the modrm form, sums the length and drives the result word
// ---------------------------------------------------------------------------
module ild_back import ild_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  item_type         item,
   output logic             rsp_valid,
   output logic [LEN_W-1:0] rsp_insn_length,
   output logic             rsp_length_valid
);

   logic [2:0]       mod_bytes;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] len_ok;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ok_ff, ok_in;

   // modrm, sib and displacement bytes
   always_comb begin
      mod_bytes = 3'd1;
      if (item.modrm[7:6] != 2'd3) begin
         if (item.modrm[2:0] == 3'd4) begin
            mod_bytes = 3'd2;
            if (item.modrm[7:6] == 2'd0 && item.sib[2:0] == 3'd5) begin
               mod_bytes = 3'd6;
            end
         end else if (item.modrm[7:6] == 2'd0 && item.modrm[2:0] == 3'd5) begin
            mod_bytes = 3'd5;
         end
         if (item.modrm[7:6] == 2'd1) begin
            mod_bytes = mod_bytes + 3'd1;
         end else if (item.modrm[7:6] == 2'd2) begin
            mod_bytes = mod_bytes + 3'd4;
         end
      end
   end

   // total length, zero when unknown or past the window
   always_comb begin
      len = LEN_W'(item.pfx_cnt) + LEN_W'(item.add);
      if (item.kind == KIND_MODRM) begin
         len = len + LEN_W'(mod_bytes);
      end
      if (item.kind == KIND_NONE || len > LEN_W'(WINDOW_BYTES)) begin
         len_ok = '0;
      end else begin
         len_ok = len;
      end
      rsp_valid_in = item_valid;
      len_in       = len_ok;
      ok_in        = (len_ok != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      ok_ff  <= ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_insn_length  = len_ff;
   assign rsp_length_valid = ok_ff;

endmodule

### rtl/x86_64_insn_length_decoder.sv
// ---------------------------------------------------------------------------
// x86_64_insn_length_decoder
// length of the first instruction in a 24-byte code window (opcode subset)
// ---------------------------------------------------------------------------
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   request  | start / busy     | req_code_bytes_lo, _mid, _hi
//   response | rsp_valid strobe | rsp_insn_length, rsp_length_valid
//
// one word per cycle sustained; an accepted word is classified by the front
// into the queue register, then summed by the back into the registered result
// the queue drains one word per cycle, so busy stays low in normal use
// synchronous reset empties the queue and drops the response strobe
// results cannot be stalled: each is shown for one cycle only
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module x86_64_insn_length_decoder import ild_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [63:0]      req_code_bytes_lo,
   input  logic [63:0]      req_code_bytes_mid,
   input  logic [63:0]      req_code_bytes_hi,
   output logic             rsp_valid,
   output logic [LEN_W-1:0] rsp_insn_length,
   output logic             rsp_length_valid
);

   item_type front_item;
   item_type head_item;
   logic     q_empty;
   logic     q_full;
   logic     push;

   // front: prefix scan and opcode classify
   ild_front u_front (
      .code_lo  (req_code_bytes_lo),
      .code_mid (req_code_bytes_mid),
      .code_hi  (req_code_bytes_hi),
      .item     (front_item)
   );

   assign push = start && !q_full;
   assign busy = q_full;

   // queue between front and back
   ild_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (!q_empty),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: length sum and result word
   ild_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (!q_empty),
      .item             (head_item),
      .rsp_valid        (rsp_valid),
      .rsp_insn_length  (rsp_insn_length),
      .rsp_length_valid (rsp_length_valid)
   );

   // checks
   `ASSERT_IMPLIES(a_flag_matches_len, clock, reset, rsp_valid,
                   rsp_length_valid == (rsp_insn_length != '0))
   `ASSERT_IMPLIES(a_len_in_window, clock, reset, rsp_valid,
                   rsp_insn_length <= LEN_W'(WINDOW_BYTES))
   `ASSERT_AFTER_TWO(a_accept_gives_result, clock, reset, start && !busy, rsp_valid)
   `ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

endmodule

### tb/x86_64_insn_length_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// x86_64_insn_length_decoder_test
// drives 24-byte code windows through the length decoder and checks each
// response word against an in-bench length predictor; directed corner cases
// come first, then mostly well-formed random instructions with some noise
// ---------------------------------------------------------------------------
module x86_64_insn_length_decoder_test import ild_pkg::*;;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_WORDS   = 400;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 50000;
   localparam int IDLE_PERCENT   = 36;
   localparam int STEADY_FIRST   = 180;
   localparam int STEADY_LAST    = 300;

   // prefixes
   localparam logic [7:0] REX_LO       = 8'h40;
   localparam logic [7:0] REX_HI       = 8'h4F;
   localparam logic [7:0] PFX_OPSIZE   = 8'h66;
   localparam logic [7:0] PFX_ADSIZE   = 8'h67;
   localparam logic [7:0] PFX_LOCK     = 8'hF0;
   localparam logic [7:0] PFX_REPNE    = 8'hF2;
   localparam logic [7:0] PFX_REP      = 8'hF3;
   localparam logic [7:0] LEGACY_PREFIXES [0:4] =
      '{PFX_OPSIZE, PFX_ADSIZE, PFX_LOCK, PFX_REPNE, PFX_REP};

   // one-byte opcodes
   localparam logic [7:0] OP_ESCAPE    = 8'h0F;
   localparam logic [7:0] OP_PUSH_LO   = 8'h50;
   localparam logic [7:0] OP_POP_HI    = 8'h5F;
   localparam logic [7:0] OP_JCC8_LO   = 8'h70;
   localparam logic [7:0] OP_JCC8_HI   = 8'h7F;
   localparam logic [7:0] OP_JMP8      = 8'hEB;
   localparam logic [7:0] OP_JMP32     = 8'hE9;
   localparam logic [7:0] OP_CALL      = 8'hE8;
   localparam logic [7:0] OP_MOVI_LO   = 8'hB8;
   localparam logic [7:0] OP_MOVI_HI   = 8'hBF;
   localparam logic [7:0] OP_PUSHI32   = 8'h68;
   localparam logic [7:0] OP_PUSHI8    = 8'h6A;
   localparam logic [7:0] OP_GRP_I8A   = 8'h80;
   localparam logic [7:0] OP_GRP_I8B   = 8'h83;
   localparam logic [7:0] OP_GRP_I32   = 8'h81;
   localparam logic [7:0] OP_MOV_I32   = 8'hC7;
   localparam logic [7:0] OP_RET       = 8'hC3;
   localparam logic [7:0] OP_RETI      = 8'hC2;
   localparam logic [7:0] OP_INT3      = 8'hCC;
   localparam logic [7:0] OP_NOP       = 8'h90;
   localparam logic [7:0] OP_UNLISTED  = 8'hF4;
   localparam logic [7:0] MODRM_OPS [0:20] = '{
      8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23, 8'h29, 8'h2B, 8'h31, 8'h33, 8'h39,
      8'h3B, 8'h63, 8'h85, 8'h86, 8'h87, 8'h89, 8'h8B, 8'h8D, 8'h8F, 8'hFF};

   // second bytes after the escape
   localparam logic [7:0] ESC_JCC32_LO = 8'h80;
   localparam logic [7:0] ESC_JCC32_HI = 8'h8F;
   localparam logic [7:0] ESC_ENDBR    = 8'h1E;
   localparam logic [7:0] ESC_NOPL     = 8'h1F;
   localparam logic [7:0] ESC_SYSCALL  = 8'h05;
   localparam logic [7:0] ESC_SYSENTER = 8'h34;
   localparam logic [7:0] ESC_UNLISTED = 8'hA2;

   // modrm / sib fields
   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP32   = 2'd2;
   localparam logic [1:0] MOD_REG      = 2'd3;
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [2:0] RM_RIP       = 3'd5;
   localparam logic [2:0] BASE_NONE    = 3'd5;

   typedef struct {
      logic [LEN_W-1:0] length;
      logic             valid;
   } length_word_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [63:0]      req_code_bytes_lo  = '0;
   logic [63:0]      req_code_bytes_mid = '0;
   logic [63:0]      req_code_bytes_hi  = '0;
   logic             rsp_valid;
   logic [LEN_W-1:0] rsp_insn_length;
   logic             rsp_length_valid;

   logic [191:0]    pending_windows [$];
   length_word_type expected_lengths [$];
   int              words_issued = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   x86_64_insn_length_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_code_bytes_lo  (req_code_bytes_lo),
      .req_code_bytes_mid (req_code_bytes_mid),
      .req_code_bytes_hi  (req_code_bytes_hi),
      .rsp_valid        (rsp_valid),
      .rsp_insn_length  (rsp_insn_length),
      .rsp_length_valid (rsp_length_valid)
   );

   always #CLOCK_HALF clock = ~clock;

   // byte k of the window, zero past its end
   function automatic logic [7:0] window_byte(input logic [191:0] win, input int k);
      if (k >= WINDOW_BYTES) return 8'h00;
      return win[8*k +: 8];
   endfunction

   // bytes taken by modrm, sib and displacement starting at k
   function automatic int modrm_span(input logic [191:0] win, input int k);
      logic [7:0] modrm;
      logic [7:0] sib;
      int         n;
      modrm = window_byte(win, k);
      sib   = window_byte(win, k + 1);
      n     = 1;
      if (modrm[7:6] == MOD_REG) return n;
      if (modrm[2:0] == RM_SIB) begin
         n += 1;
         if (modrm[7:6] == MOD_INDIRECT && sib[2:0] == BASE_NONE) n += 4;
      end else if (modrm[7:6] == MOD_INDIRECT && modrm[2:0] == RM_RIP) begin
         n += 4;
      end
      if (modrm[7:6] == MOD_DISP8) n += 1;
      else if (modrm[7:6] == MOD_DISP32) n += 4;
      return n;
   endfunction

   // raw decoded length, 0 when not recognized
   function automatic int decode_length(input logic [191:0] win);
      int         i;
      logic       rex_w;
      logic       scanning;
      logic       legacy;
      logic       modrm_only;
      logic [7:0] b;
      logic [7:0] op;
      logic [7:0] op2;
      i = 0;
      rex_w = 1'b0;
      scanning = 1'b1;
      // skip legacy and rex prefixes, last rex decides W
      while (scanning && i < MAX_PREFIX_BYTES) begin
         b = window_byte(win, i);
         legacy = 1'b0;
         foreach (LEGACY_PREFIXES[p]) if (b == LEGACY_PREFIXES[p]) legacy = 1'b1;
         if (b >= REX_LO && b <= REX_HI) begin
            rex_w = b[3];
            i++;
         end else if (legacy) begin
            i++;
         end else begin
            scanning = 1'b0;
         end
      end
      if (i >= MAX_PREFIX_BYTES) return 0;
      op  = window_byte(win, i);
      op2 = window_byte(win, i + 1);
      if (op == OP_ESCAPE) begin
         if (op2 >= ESC_JCC32_LO && op2 <= ESC_JCC32_HI) return i + 6;
         if (op2 == ESC_ENDBR || op2 == ESC_NOPL) return i + 2 + modrm_span(win, i + 2);
         if (op2 == ESC_SYSCALL || op2 == ESC_SYSENTER) return i + 2;
         return 0;
      end
      if (op >= OP_PUSH_LO && op <= OP_POP_HI) return i + 1;
      if (op >= OP_JCC8_LO && op <= OP_JCC8_HI) return i + 2;
      if (op == OP_JMP8) return i + 2;
      if (op == OP_JMP32 || op == OP_CALL) return i + 5;
      if (op >= OP_MOVI_LO && op <= OP_MOVI_HI) return i + 1 + (rex_w ? 8 : 4);
      if (op == OP_PUSHI32) return i + 5;
      if (op == OP_PUSHI8) return i + 2;
      if (op == OP_GRP_I8A || op == OP_GRP_I8B) return i + 2 + modrm_span(win, i + 1);
      if (op == OP_GRP_I32 || op == OP_MOV_I32) return i + 5 + modrm_span(win, i + 1);
      modrm_only = 1'b0;
      foreach (MODRM_OPS[m]) if (op == MODRM_OPS[m]) modrm_only = 1'b1;
      if (modrm_only) return i + 1 + modrm_span(win, i + 1);
      if (op == OP_RET || op == OP_INT3 || op == OP_NOP) return i + 1;
      if (op == OP_RETI) return i + 3;
      return 0;
   endfunction

   // window of random bytes with the given leading bytes
   function automatic logic [191:0] fill_window(input logic [7:0] head [$]);
      logic [191:0] w;
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      for (int k = 0; k < head.size() && k < WINDOW_BYTES; k++) w[8*k +: 8] = head[k];
      return w;
   endfunction

   // random prefix byte, rex or legacy
   function automatic logic [7:0] random_prefix();
      if ($urandom_range(0, 1)) return REX_LO + 8'($urandom_range(0, 15));
      return LEGACY_PREFIXES[$urandom_range(0, 4)];
   endfunction

   // modrm byte biased toward sib and rip-relative forms
   function automatic logic [7:0] random_modrm();
      logic [7:0] m;
      int         pick;
      m = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 5) m[2:0] = RM_SIB;
      else if (pick < 7) m[2:0] = RM_RIP;
      return m;
   endfunction

   // mostly well-formed instruction with random content
   function automatic logic [191:0] random_insn();
      logic [7:0] head [$];
      logic [7:0] sib;
      int         n_prefix;
      head = {};
      n_prefix = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
      repeat (n_prefix) head.push_back(random_prefix());
      case ($urandom_range(0, 10))
         0: begin
            head.push_back(OP_ESCAPE);
            case ($urandom_range(0, 5))
               0: head.push_back(ESC_JCC32_LO + 8'($urandom_range(0, 15)));
               1: head.push_back(ESC_ENDBR);
               2: head.push_back(ESC_NOPL);
               3: head.push_back(ESC_SYSCALL);
               4: head.push_back(ESC_SYSENTER);
               default: head.push_back(8'($urandom));
            endcase
         end
         1: head.push_back(OP_PUSH_LO + 8'($urandom_range(0, 15)));
         2: head.push_back(OP_JCC8_LO + 8'($urandom_range(0, 15)));
         3: begin
            case ($urandom_range(0, 2))
               0: head.push_back(OP_JMP8);
               1: head.push_back(OP_JMP32);
               default: head.push_back(OP_CALL);
            endcase
         end
         4: head.push_back(OP_MOVI_LO + 8'($urandom_range(0, 7)));
         5: head.push_back($urandom_range(0, 1) ? OP_PUSHI32 : OP_PUSHI8);
         6: begin
            case ($urandom_range(0, 3))
               0: head.push_back(OP_GRP_I8A);
               1: head.push_back(OP_GRP_I8B);
               2: head.push_back(OP_GRP_I32);
               default: head.push_back(OP_MOV_I32);
            endcase
         end
         7, 8: head.push_back(MODRM_OPS[$urandom_range(0, 20)]);
         9: begin
            case ($urandom_range(0, 3))
               0: head.push_back(OP_RET);
               1: head.push_back(OP_RETI);
               2: head.push_back(OP_INT3);
               default: head.push_back(OP_NOP);
            endcase
         end
         default: head.push_back(8'($urandom));
      endcase
      // modrm and sib right after the opcode bytes
      sib = 8'($urandom);
      if ($urandom_range(0, 1)) sib[2:0] = BASE_NONE;
      head.push_back(random_modrm());
      head.push_back(sib);
      return fill_window(head);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // stimulus, reset and end of run
   initial begin
      logic [7:0] hd [$];
      // too many prefixes
      hd = {};
      for (int k = 0; k < MAX_PREFIX_BYTES; k++)
         hd.push_back((k % 3 == 0) ? REX_LO + 8'(k) : LEGACY_PREFIXES[k % 5]);
      pending_windows.push_back(fill_window(hd));
      // one prefix short of the limit, then a short opcode
      void'(hd.pop_back());
      hd.push_back(OP_NOP);
      pending_windows.push_back(fill_window(hd));
      // decoded length past the window
      void'(hd.pop_back());
      hd.push_back(OP_GRP_I32);
      hd.push_back({MOD_INDIRECT, 3'b000, RM_SIB});
      hd.push_back({5'b00000, BASE_NONE});
      pending_windows.push_back(fill_window(hd));
      // long form that still fits
      repeat (3) void'(hd.pop_back());
      hd.push_back(OP_ESCAPE);
      hd.push_back(ESC_NOPL);
      hd.push_back({MOD_DISP32, 3'b000, RM_SIB});
      pending_windows.push_back(fill_window(hd));
      // escape forms
      hd = '{OP_ESCAPE, ESC_JCC32_LO};           pending_windows.push_back(fill_window(hd));
      hd = '{OP_ESCAPE, ESC_JCC32_HI};           pending_windows.push_back(fill_window(hd));
      hd = '{OP_ESCAPE, ESC_ENDBR, {MOD_REG, 6'b000000}};
      pending_windows.push_back(fill_window(hd));
      hd = '{OP_ESCAPE, ESC_SYSCALL};            pending_windows.push_back(fill_window(hd));
      hd = '{OP_ESCAPE, ESC_SYSENTER};           pending_windows.push_back(fill_window(hd));
      hd = '{OP_ESCAPE, ESC_UNLISTED};           pending_windows.push_back(fill_window(hd));
      // fixed-length opcodes
      hd = '{OP_PUSH_LO};                        pending_windows.push_back(fill_window(hd));
      hd = '{OP_POP_HI};                         pending_windows.push_back(fill_window(hd));
      hd = '{OP_JCC8_HI};                        pending_windows.push_back(fill_window(hd));
      hd = '{OP_JMP8};                           pending_windows.push_back(fill_window(hd));
      hd = '{OP_JMP32};                          pending_windows.push_back(fill_window(hd));
      hd = '{OP_CALL};                           pending_windows.push_back(fill_window(hd));
      // mov immediate, last rex decides W
      hd = '{REX_HI, OP_MOVI_LO};                pending_windows.push_back(fill_window(hd));
      hd = '{REX_HI, REX_LO, OP_MOVI_HI};        pending_windows.push_back(fill_window(hd));
      hd = '{OP_PUSHI32};                        pending_windows.push_back(fill_window(hd));
      hd = '{OP_PUSHI8};                         pending_windows.push_back(fill_window(hd));
      // group/mov imm with sib, disp and rip forms; reg modrm, ret imm, int3, unlisted
      hd = '{OP_GRP_I8A, {MOD_DISP8, 3'b000, RM_SIB}};
      pending_windows.push_back(fill_window(hd));
      hd = '{OP_MOV_I32, {MOD_INDIRECT, 3'b000, RM_RIP}};
      pending_windows.push_back(fill_window(hd));
      hd = '{OP_GRP_I8B, {MOD_INDIRECT, 3'b000, RM_SIB}, {5'b00000, BASE_NONE}};
      pending_windows.push_back(fill_window(hd));
      hd = '{MODRM_OPS[0], {MOD_REG, 6'b000000}};
      pending_windows.push_back(fill_window(hd));
      hd = '{OP_RETI};                           pending_windows.push_back(fill_window(hd));
      hd = '{OP_INT3};                           pending_windows.push_back(fill_window(hd));
      hd = '{OP_UNLISTED};                       pending_windows.push_back(fill_window(hd));
      // all-zero and all-one windows
      pending_windows.push_back('0);
      pending_windows.push_back('1);
      // random part: mostly real instructions, some pure noise
      repeat (RANDOM_WORDS) begin
         if ($urandom_range(0, 99) < 15) begin
            hd = {};
            pending_windows.push_back(fill_window(hd));
         end else begin
            pending_windows.push_back(random_insn());
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_windows.size() != 0 || start) @(posedge clock);
      while (expected_lengths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_lengths.size() != 0) begin
         report_mismatch("missing response word, want length", 0,
                         expected_lengths[0].length);
         void'(expected_lengths.pop_front());
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // driver: holds a word until accepted, idles at random outside the steady stretch
   always @(posedge clock) begin
      logic [191:0] w;
      logic [191:0] taken;
      int           len;
      logic         idle;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            taken = {req_code_bytes_hi, req_code_bytes_mid, req_code_bytes_lo};
            len = decode_length(taken);
            if (len > WINDOW_BYTES) len = 0;
            expected_lengths.push_back('{length: LEN_W'(len), valid: (len != 0)});
         end
         if (!start || !busy) begin
            idle = (words_issued >= STEADY_FIRST && words_issued < STEADY_LAST) ? 1'b0 :
                   ($urandom_range(0, 99) < IDLE_PERCENT);
            if (pending_windows.size() != 0 && !idle) begin
               w = pending_windows.pop_front();
               req_code_bytes_lo  <= w[63:0];
               req_code_bytes_mid <= w[127:64];
               req_code_bytes_hi  <= w[191:128];
               start <= 1'b1;
               words_issued++;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: each strobed response word against the oldest expectation
   always @(posedge clock) begin
      length_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_lengths.size() == 0) begin
            report_mismatch("response word with none outstanding, length", rsp_insn_length, 0);
         end else begin
            want = expected_lengths.pop_front();
            if (rsp_insn_length !== want.length)
               report_mismatch("insn_length", rsp_insn_length, want.length);
            if (rsp_length_valid !== want.valid)
               report_mismatch("length_valid", rsp_length_valid, want.valid);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

### x86_64_insn_length_decoder.f
+incdir+rtl
rtl/ild_pkg.sv
rtl/ild_front.sv
rtl/ild_queue.sv
rtl/ild_back.sv
rtl/x86_64_insn_length_decoder.sv
tb/x86_64_insn_length_decoder_test.sv
